### rtl/bm25_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_pkg
// Shared types and constants for the BM25 term score accumulator.
// ----------------------------------------------------------------------------
package bm25_pkg;

    // Field widths of the item and register interface.
    localparam int IDF_W   = 24;
    localparam int AVG_W   = 20;
    localparam int ID_W    = 10;
    localparam int TF_W    = 16;
    localparam int LEN_W   = 20;
    localparam int SCORE_W = 32;

    // Divider operand widths. The numerator stays below 2^64, the
    // denominator below 2^40 and the quotient below 2^25.
    localparam int NUM_W = 64;
    localparam int DEN_W = 40;
    localparam int QUO_W = 25;

    // Signed term score width: one sign bit over the quotient.
    localparam int TERM_W = QUO_W + 1;

    // Half-width split of the first product for the numerator multiply.
    localparam int P1_W   = IDF_W + TF_W;
    localparam int HALF_W = P1_W / 2;
    localparam int A22_W  = AVG_W + 5;
    localparam int PP_W   = HALF_W + A22_W;

    // Constant factors of the score formula.
    localparam logic [4:0] K_NUM = 5'd22;
    localparam logic [3:0] K_TF  = 4'd10;
    localparam logic [1:0] K_AVG = 2'd3;
    localparam logic [3:0] K_LEN = 4'd9;

    // Register indexes.
    localparam logic CFG_IDF = 1'b0;
    localparam logic CFG_AVG = 1'b1;

    // Commands.
    localparam logic CMD_ACC  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Saturation limits.
    localparam logic [SCORE_W-1:0] SAT_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic [SCORE_W-1:0] SAT_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    // Main sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_WAIT,
        S_COMMIT
    } t_ctrl_state;

    // Term score unit states.
    typedef enum logic [2:0] {
        T_IDLE,
        T_MUL1,
        T_MUL2,
        T_MUL3,
        T_SUM,
        T_DIV,
        T_DONE
    } t_term_state;

    // Status from the term score unit to the sequencer.
    typedef struct packed {
        logic                     done;
        logic signed [TERM_W-1:0] score;
    } t_term_res;

endpackage

### rtl/bm25_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_mem
// Score store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bm25_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 33
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bm25_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bm25_div
    import bm25_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [QUO_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUO_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;
    logic [DEN_W+1:0] trial;
    logic             borrow;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign trial  = {1'b0, r_rem, r_quo[QUO_W-1]} - {2'b00, r_den};
    assign borrow = trial[DEN_W+1];

    // Control: count quotient bits while busy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QUO_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: the top numerator bits seed the remainder, the low bits
    // shift out while the quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'(i_num[NUM_W-1:QUO_W]);
            r_quo <= i_num[QUO_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            if (borrow) begin
                r_rem <= {r_rem[DEN_W-2:0], r_quo[QUO_W-1]};
            end else begin
                r_rem <= trial[DEN_W-1:0];
            end
            r_quo <= {r_quo[QUO_W-2:0], ~borrow};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

### rtl/bm25_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_term
// Term score unit: builds numerator and denominator with registered
// multiplies, then runs the divider and applies the IDF sign.
// ----------------------------------------------------------------------------
module bm25_term
    import bm25_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IDF_W-1:0] i_idf,
    input  logic [AVG_W-1:0] i_avg,
    input  logic [TF_W-1:0]  i_tf,
    input  logic [LEN_W-1:0] i_len,
    output t_term_res        o_res
);

    t_term_state r_state;
    t_term_state n_state;

    logic             r_neg;
    logic [IDF_W-1:0] r_mag;
    logic [AVG_W-1:0] r_avg;
    logic [TF_W-1:0]  r_tf;
    logic [LEN_W-1:0] r_len;
    logic [P1_W-1:0]  r_p1;
    logic [AVG_W+TF_W-1:0] r_at;
    logic [A22_W-1:0] r_avg22;
    logic [PP_W-1:0]  r_pp;
    logic [PP_W-1:0]  r_pl;
    logic [DEN_W-1:0] r_den;

    logic             div_start;
    logic             div_busy;
    logic [QUO_W-1:0] div_quot;
    logic [NUM_W-1:0] num;
    logic [TERM_W-1:0] quot_ext;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE:  if (i_start) n_state = T_MUL1;
            T_MUL1:  n_state = T_MUL2;
            T_MUL2:  n_state = T_MUL3;
            T_MUL3:  n_state = T_SUM;
            T_SUM:   n_state = T_DIV;
            T_DIV:   if (!div_busy) n_state = T_DONE;
            T_DONE:  if (i_start) n_state = T_MUL1;
            default: n_state = T_IDLE;
        endcase
    end

    // Outputs. A negative IDF negates the truncated quotient.
    always_comb begin
        div_start   = (r_state == T_SUM);
        o_res.done  = (r_state == T_DONE);
        o_res.score = r_neg ? $signed(TERM_W'(0) - quot_ext) : $signed(quot_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operand capture: IDF magnitude and sign, zero average taken as one.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_idf[IDF_W-1];
            r_mag <= i_idf[IDF_W-1] ? (IDF_W'(0) - i_idf) : i_idf;
            r_avg <= (i_avg == '0) ? AVG_W'(1) : i_avg;
            r_tf  <= i_tf;
            r_len <= i_len;
        end
    end

    // Multiply steps, spread over the T_MUL1, T_MUL2 and T_MUL3 states.
    always_ff @(posedge i_clk) begin
        case (r_state)
            T_MUL1: begin
                r_p1    <= P1_W'(r_mag) * P1_W'(r_tf);
                r_at    <= (AVG_W+TF_W)'(r_avg) * (AVG_W+TF_W)'(r_tf);
                r_avg22 <= A22_W'(r_avg) * A22_W'(K_NUM);
            end
            T_MUL2: begin
                r_pp  <= PP_W'(r_p1[P1_W-1:HALF_W]) * PP_W'(r_avg22);
                r_den <= DEN_W'(r_at) * DEN_W'(K_TF)
                       + DEN_W'(r_avg) * DEN_W'(K_AVG)
                       + DEN_W'(r_len) * DEN_W'(K_LEN);
            end
            T_MUL3: begin
                r_pl <= PP_W'(r_p1[HALF_W-1:0]) * PP_W'(r_avg22);
            end
            default: begin
            end
        endcase
    end

    // Recombine the two partial products into the numerator.
    assign num = NUM_W'({r_pp, HALF_W'(0)}) + NUM_W'(r_pl);

    bm25_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    assign quot_ext = TERM_W'(div_quot);

endmodule

### rtl/bm25_term_score_accumulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_term_score_accumulator_top
// BM25 term score accumulator: per-document Q16.16 score store with
// read-and-clear, fed by a sequential term score unit.
// ----------------------------------------------------------------------------
// Items are worked one at a time. An accumulate item inside the store waits for
// the 25-step divider before its result appears; read items and items outside
// the store skip the term score unit.
// Reset: synchronous, active low. After reset the store is cleared, all MAX_DOCS
// entries, one entry per cycle, before the first item is taken.
// ----------------------------------------------------------------------------
module bm25_term_score_accumulator_top
    import bm25_pkg::*;
#(
    parameter int MAX_DOCS = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_command,
    input  logic [ID_W-1:0]           i_doc_id,
    input  logic [TF_W-1:0]           i_term_count,
    input  logic [LEN_W-1:0]          i_doc_words,
    // Output channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [ID_W-1:0]           o_out_doc,
    output logic signed [SCORE_W-1:0] o_acc_score,
    output logic                      o_seen,
    // Configuration port
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [IDF_W-1:0]          i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_DOCS);
    localparam int WORD_W = SCORE_W + 1;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    logic [IDF_W-1:0]   r_idf;
    logic [AVG_W-1:0]   r_avg;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_cmd;
    logic               r_in_range;
    logic [ID_W-1:0]    r_doc;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_doc;
    logic [SCORE_W-1:0] r_out_score;
    logic               r_out_seen;

    logic               in_acc;
    logic               out_free;
    logic               clearing;
    logic               commit;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [WORD_W-1:0]  mem_rdata;
    t_term_res          term_res;

    logic [SCORE_W-1:0] old_score;
    logic               old_seen;
    logic [SCORE_W:0]   sum;
    logic [SCORE_W-1:0] sat_score;
    logic [SCORE_W-1:0] res_score;
    logic               res_seen;
    logic [WORD_W-1:0]  new_word;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idf <= '0;
            r_avg <= AVG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDF: r_idf <= i_cfg_data;
                CFG_AVG: r_avg <= i_cfg_data[AVG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr_addr == ADDR_W'(MAX_DOCS - 1)) n_state = S_IDLE;
            S_IDLE:   if (in_acc) n_state = S_FETCH;
            S_FETCH:  n_state = S_WAIT;
            S_WAIT: begin
                if (r_cmd == CMD_READ || !r_in_range || term_res.done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: if (out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_stall  = (r_state != S_IDLE);
        clearing = (r_state == S_CLEAR);
        commit   = (r_state == S_COMMIT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd      <= i_command;
            r_doc      <= i_doc_id;
            r_addr     <= ADDR_W'(i_doc_id);
            r_in_range <= (32'(i_doc_id) < MAX_DOCS);
        end
    end

    // The term score unit only runs for accumulate items inside the store.
    bm25_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && (i_command == CMD_ACC) && (32'(i_doc_id) < MAX_DOCS)),
        .i_idf   (r_idf),
        .i_avg   (r_avg),
        .i_tf    (i_term_count),
        .i_len   (i_doc_words),
        .o_res   (term_res)
    );

    // Read-modify-write: add the term score with saturation.
    assign old_seen  = mem_rdata[SCORE_W];
    assign old_score = mem_rdata[SCORE_W-1:0];
    assign sum = {old_score[SCORE_W-1], old_score}
               + (SCORE_W+1)'($signed(term_res.score));
    assign sat_score = (sum[SCORE_W] != sum[SCORE_W-1])
                     ? (sum[SCORE_W] ? SAT_MIN : SAT_MAX)
                     : sum[SCORE_W-1:0];

    always_comb begin
        res_score = '0;
        res_seen  = 1'b0;
        new_word  = '0;
        if (r_in_range) begin
            res_seen = old_seen;
            if (r_cmd == CMD_READ) begin
                res_score = old_score;
            end else begin
                res_score = sat_score;
                new_word  = {1'b1, sat_score};
            end
        end
    end

    // Store write port: clearing pass or commit of the current item.
    assign mem_we    = clearing || (commit && r_in_range);
    assign mem_waddr = clearing ? r_clr_addr : r_addr;
    assign mem_wdata = clearing ? WORD_W'(0) : new_word;

    bm25_mem #(
        .DEPTH  (MAX_DOCS),
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_doc   <= r_doc;
            r_out_score <= res_score;
            r_out_seen  <= res_seen;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_doc   = r_out_doc;
    assign o_acc_score = $signed(r_out_score);
    assign o_seen      = r_out_seen;

endmodule

### rtl/bm25_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_chk
// Port-level checks for the BM25 term score accumulator.
// ----------------------------------------------------------------------------
module bm25_chk
    import bm25_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [ID_W-1:0]           o_out_doc,
    input logic signed [SCORE_W-1:0] o_acc_score,
    input logic                      o_seen
);

    // A result held back by the receiver stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // A held result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out_doc) && $stable(o_acc_score)
                               && $stable(o_seen))
        else $error("stalled result changed");

    // Items are worked one at a time: the block stalls right after taking one.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken while one is in work");

    // Reset empties the output and starts the clearing pass.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("block not quiet after reset");

endmodule

bind bm25_term_score_accumulator_top bm25_chk u_bm25_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_doc   (o_out_doc),
    .o_acc_score (o_acc_score),
    .o_seen      (o_seen)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the BM25 term score accumulator. A directed table
// covers reset state, field extremes, both commands, negative and zero
// weights and a zero average. Random phases with different idling patterns,
// a long output hold-off and two saturation runs follow. Each result is
// checked field by field against its typed table value or else against a
// bit-accurate bench predictor of the score store, run as items are taken.
// ----------------------------------------------------------------------------
module tb;
    import bm25_pkg::*;

    localparam int MAX_DOCS = 1024;

    // One expected result item.
    typedef struct packed {
        logic [ID_W-1:0]    doc;
        logic [SCORE_W-1:0] score;
        logic               seen;
    } t_result;

    typedef enum {ROW_ITEM, ROW_CFG} t_row_kind;

    // One row of the directed table: an item or a pair of register writes.
    typedef struct {
        t_row_kind        kind;
        logic             cmd;
        logic [ID_W-1:0]  doc;
        logic [TF_W-1:0]  tf;
        logic [LEN_W-1:0] len;
        logic [IDF_W-1:0] idf_data;
        logic [IDF_W-1:0] avg_data;
        bit               typed;
        t_result          want;
    } t_row;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_valid      = 1'b0;
    logic                      o_stall;
    logic                      i_command    = CMD_ACC;
    logic [ID_W-1:0]           i_doc_id     = '0;
    logic [TF_W-1:0]           i_term_count = '0;
    logic [LEN_W-1:0]          i_doc_words  = '0;
    logic                      o_valid;
    logic                      i_stall      = 1'b0;
    logic [ID_W-1:0]           o_out_doc;
    logic signed [SCORE_W-1:0] o_acc_score;
    logic                      o_seen;
    logic                      i_cfg_we     = 1'b0;
    logic                      i_cfg_idx    = CFG_IDF;
    logic [IDF_W-1:0]          i_cfg_data   = '0;

    // Mirror of the block's store and registers.
    logic [SCORE_W-1:0] score_mirror [MAX_DOCS];
    bit                 seen_mirror  [MAX_DOCS];
    logic [IDF_W-1:0]   idf_mirror = '0;
    logic [AVG_W-1:0]   avg_mirror = 1;

    t_result expected_results [$];
    t_row    directed_rows [$];

    // Idling controls for the sender and the receiver.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_cycles   = 0;

    // Run statistics.
    int mismatches      = 0;
    int items_sent      = 0;
    int reads_sent      = 0;
    int cfg_writes      = 0;
    int results_checked = 0;
    int seen_hits       = 0;
    int clamped_sums    = 0;

    bm25_term_score_accumulator_top #(
        .MAX_DOCS(MAX_DOCS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_doc_id    (i_doc_id),
        .i_term_count(i_term_count),
        .i_doc_words (i_doc_words),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_doc   (o_out_doc),
        .o_acc_score (o_acc_score),
        .o_seen      (o_seen),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Signed Q16.16 term score of one posting under the mirrored registers.
    // The length ratio stays an exact fraction; the quotient truncates.
    function automatic longint posting_score(input logic [TF_W-1:0] tf,
                                             input logic [LEN_W-1:0] len);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] avg;
        logic [63:0] num;
        logic [63:0] den;
        neg = idf_mirror[IDF_W-1];
        mag = neg ? (64'd1 << IDF_W) - 64'(idf_mirror) : 64'(idf_mirror);
        avg = (avg_mirror == '0) ? 64'd1 : 64'(avg_mirror);
        num = mag * 64'(tf) * 64'd22 * avg;
        den = 64'd10 * avg * 64'(tf) + 64'd3 * avg + 64'd9 * 64'(len);
        return neg ? -longint'(num / den) : longint'(num / den);
    endfunction

    // Applies one accepted item to the mirror and returns its result.
    function automatic t_result apply_item(input logic cmd, input logic [ID_W-1:0] doc,
                                           input logic [TF_W-1:0] tf,
                                           input logic [LEN_W-1:0] len);
        t_result res;
        longint  total;
        res.doc   = doc;
        res.score = '0;
        res.seen  = 1'b0;
        if (int'(doc) < MAX_DOCS) begin
            res.seen = seen_mirror[doc];
            if (cmd == CMD_READ) begin
                res.score         = score_mirror[doc];
                score_mirror[doc] = '0;
                seen_mirror[doc]  = 1'b0;
            end else begin
                total = longint'($signed(score_mirror[doc])) + posting_score(tf, len);
                if (total > longint'($signed(SAT_MAX))) begin
                    total = longint'($signed(SAT_MAX));
                    clamped_sums++;
                end else if (total < longint'($signed(SAT_MIN))) begin
                    total = longint'($signed(SAT_MIN));
                    clamped_sums++;
                end
                res.score         = total[SCORE_W-1:0];
                score_mirror[doc] = total[SCORE_W-1:0];
                seen_mirror[doc]  = 1'b1;
            end
        end
        return res;
    endfunction

    // Table builders for the directed part.
    function automatic void add_item_row(input logic cmd, input int doc, input int tf,
                                         input int len, input bit typed,
                                         input int score, input bit seen);
        t_row r;
        r.kind     = ROW_ITEM;
        r.cmd      = cmd;
        r.doc      = ID_W'(doc);
        r.tf       = TF_W'(tf);
        r.len      = LEN_W'(len);
        r.idf_data = '0;
        r.avg_data = '0;
        r.typed    = typed;
        r.want     = {ID_W'(doc), SCORE_W'(score), seen};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_cfg_row(input logic [IDF_W-1:0] idf,
                                        input logic [IDF_W-1:0] avg);
        t_row r;
        r.kind     = ROW_CFG;
        r.cmd      = CMD_ACC;
        r.doc      = '0;
        r.tf       = '0;
        r.len      = '0;
        r.idf_data = idf;
        r.avg_data = avg;
        r.typed    = 1'b0;
        r.want     = '0;
        directed_rows.push_back(r);
    endfunction

    // Prints one line per mismatch, up to a cap, and counts them all.
    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        if (mismatches < 100)
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offers one item and waits for it to be taken, then records its result.
    task automatic send_item(input logic cmd, input logic [ID_W-1:0] doc,
                             input logic [TF_W-1:0] tf, input logic [LEN_W-1:0] len,
                             input bit typed, input t_result want);
        t_result res;
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_doc_id     <= doc;
        i_term_count <= tf;
        i_doc_words  <= len;
        do @(posedge i_clk); while (!(i_valid === 1'b1 && o_stall === 1'b0));
        res = apply_item(cmd, doc, tf, len);
        expected_results.push_back(typed ? want : res);
        items_sent++;
        if (cmd == CMD_READ) reads_sent++;
    endtask

    // Random pause on the sending side.
    task automatic sender_gap();
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Stops sending until every expected result has come back.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back edges while the block is idle.
    task automatic set_config(input logic [IDF_W-1:0] idf, input logic [IDF_W-1:0] avg);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDF;
        i_cfg_data <= idf;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_AVG;
        i_cfg_data <= avg;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        idf_mirror = idf;
        avg_mirror = avg[AVG_W-1:0];
        cfg_writes += 2;
    endtask

    // Random weight, and an average that is either small or anywhere in
    // range, with junk in the unused high data bits.
    task automatic set_random_config();
        logic [AVG_W-1:0] avg;
        avg = $urandom_range(1) ? AVG_W'($urandom) : AVG_W'($urandom_range(200, 1));
        set_config(IDF_W'($urandom), {4'($urandom), avg});
    endtask

    // One random phase. Most items hit a small working set of documents so
    // that scores build up and reads find them; the rest land anywhere.
    // Heavy phases pile large postings onto few documents to saturate.
    task automatic run_phase(input int send_pct, input int rx_pct, input int count,
                             input int read_pct, input int span, input bit heavy);
        logic [ID_W-1:0]  base;
        logic             cmd;
        logic [ID_W-1:0]  doc;
        logic [TF_W-1:0]  tf;
        logic [LEN_W-1:0] len;
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
        base = ID_W'($urandom_range(MAX_DOCS - span));
        for (int k = 0; k < count; k++) begin
            cmd = ($urandom_range(99) < read_pct) ? CMD_READ : CMD_ACC;
            if (heavy || $urandom_range(99) < 75)
                doc = base + ID_W'($urandom_range(span - 1));
            else
                doc = ID_W'($urandom);
            if (heavy) begin
                tf  = TF_W'($urandom_range(65535, 1000));
                len = LEN_W'($urandom_range(int'(avg_mirror)));
            end else begin
                case ($urandom_range(9))
                    0:       tf = '0;
                    1, 2, 3: tf = TF_W'($urandom);
                    default: tf = TF_W'($urandom_range(40, 1));
                endcase
                if ($urandom_range(99) < 40)
                    len = LEN_W'($urandom);
                else
                    len = LEN_W'($urandom_range(2 * int'(avg_mirror)));
            end
            sender_gap();
            send_item(cmd, doc, tf, len, 1'b0, '0);
        end
    endtask

    // Result checker and stall driver. A pending hold-off keeps the output
    // stalled for a counted stretch; otherwise stalls are random.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, doc", longint'(o_out_doc), -1);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.seen) seen_hits++;
                if (o_out_doc !== want.doc)
                    report_mismatch("out_doc", longint'(o_out_doc), longint'(want.doc));
                if (o_acc_score !== want.score)
                    report_mismatch("acc_score", longint'(o_acc_score),
                                    longint'($signed(want.score)));
                if (o_seen !== want.seen)
                    report_mismatch("seen", longint'(o_seen), longint'(want.seen));
            end
        end
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles--;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Stimulus.
    initial begin
        for (int d = 0; d < MAX_DOCS; d++) begin
            score_mirror[d] = '0;
            seen_mirror[d]  = 1'b0;
        end

        // Reset values: zero weight, so every score stays zero.
        add_item_row(CMD_READ, 0, 0, 0, 1'b1, 0, 1'b0);
        add_item_row(CMD_ACC, 1023, 65535, 20'hFFFFF, 1'b1, 0, 1'b0);
        add_item_row(CMD_ACC, 1023, 0, 0, 1'b1, 0, 1'b1);
        add_item_row(CMD_READ, 1023, 0, 0, 1'b1, 0, 1'b1);
        add_item_row(CMD_READ, 1023, 0, 0, 1'b1, 0, 1'b0);
        // Largest weight and largest average; a zero term count included.
        add_cfg_row(24'h7FFFFF, 24'h0FFFFF);
        add_item_row(CMD_ACC, 5, 65535, 0, 1'b0, 0, 1'b0);
        add_item_row(CMD_ACC, 5, 1, 20'hFFFFF, 1'b0, 0, 1'b0);
        add_item_row(CMD_ACC, 5, 0, 12345, 1'b0, 0, 1'b0);
        add_item_row(CMD_READ, 5, 0, 0, 1'b0, 0, 1'b0);
        // Most negative weight; a zero average with high junk bits.
        add_cfg_row(24'h800000, 24'hF00000);
        add_item_row(CMD_ACC, 6, 65535, 20'hFFFFF, 1'b0, 0, 1'b0);
        add_item_row(CMD_ACC, 6, 1, 0, 1'b0, 0, 1'b0);
        add_item_row(CMD_ACC, 6, 0, 0, 1'b0, 0, 1'b0);
        add_item_row(CMD_READ, 6, 0, 0, 1'b0, 0, 1'b0);
        // Weight of one with a typical average.
        add_cfg_row(24'h010000, 24'h000064);
        add_item_row(CMD_ACC, 512, 3, 100, 1'b0, 0, 1'b0);
        add_item_row(CMD_ACC, 512, 3, 300, 1'b0, 0, 1'b0);
        add_item_row(CMD_READ, 512, 0, 0, 1'b0, 0, 1'b0);
        add_item_row(CMD_READ, 512, 0, 0, 1'b1, 0, 1'b0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, sent back to back.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                drain();
                set_config(directed_rows[r].idf_data, directed_rows[r].avg_data);
            end else begin
                send_item(directed_rows[r].cmd, directed_rows[r].doc, directed_rows[r].tf,
                          directed_rows[r].len, directed_rows[r].typed,
                          directed_rows[r].want);
            end
        end

        // Random phases under each idling pattern.
        drain();
        set_random_config();
        run_phase(0, 0, 150, 20, 16, 1'b0);
        drain();
        set_random_config();
        run_phase(86, 0, 100, 20, 16, 1'b0);
        drain();
        set_random_config();
        run_phase(0, 86, 100, 20, 16, 1'b0);
        drain();
        set_random_config();
        run_phase(26, 26, 100, 20, 16, 1'b0);

        // Long output hold-off while items keep coming, so the input stalls.
        drain();
        set_random_config();
        hold_cycles = 300;
        run_phase(0, 0, 12, 20, 16, 1'b0);

        // Drive one document into positive, then one into negative saturation.
        drain();
        set_config(24'h7FFFFF, IDF_W'($urandom_range(1000, 1)));
        run_phase(26, 26, 130, 0, 1, 1'b1);
        drain();
        set_config(24'h800000, IDF_W'($urandom_range(1000, 1)));
        run_phase(26, 26, 140, 0, 1, 1'b1);

        drain();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d items (%0d reads) over %0d register writes and 7 random phases.",
                 items_sent, reads_sent, cfg_writes);
        $display("Checked %0d results: %0d on documents already scored, %0d clamped sums.",
                 results_checked, seen_hits, clamped_sums);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("Timeout with %0d results still expected.", expected_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
